// ===== rtl/gfvo_pkg.sv =====
// Shared definitions for the GF(256) symbol vector block: lane counts,
// operation codes, the control struct and field arithmetic (poly 0x11D).
// No dependencies.
`timescale 1ns / 1ps

package gfvo_pkg;

    localparam int LANES      = 4;
    localparam int WORD_BYTES = 4;
    localparam int ACT_LANES  = (LANES < WORD_BYTES) ? LANES : WORD_BYTES;
    localparam int WORD_W     = WORD_BYTES * 8;

    localparam logic [8:0] GF_POLY = 9'h11D;

    localparam logic [1:0] OP_XOR    = 2'd0;
    localparam logic [1:0] OP_MUL    = 2'd1;
    localparam logic [1:0] OP_DIV    = 2'd2;
    localparam logic [1:0] OP_MULADD = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       div_zero;
        logic       last;
    } t_ctrl;

    typedef logic [255:0][7:0] t_inv_tab;

    // Shift-and-add multiply with reduction after every shift.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sh;
        logic [7:0] prod;
        sh   = {1'b0, a};
        prod = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                prod = prod ^ sh[7:0];
            end
            sh = {sh[7:0], 1'b0};
            if (sh[8]) begin
                sh = sh ^ GF_POLY;
            end
        end
        return prod;
    endfunction

    // Builds the inverse table as b^254; zero maps to zero.
    function automatic t_inv_tab gf_inv_table();
        t_inv_tab   tab;
        logic [7:0] acc;
        logic [7:0] base;
        logic [7:0] e;
        for (int v = 0; v < 256; v++) begin
            acc  = 8'h01;
            base = v[7:0];
            e    = 8'd254;
            for (int k = 0; k < 8; k++) begin
                if (e[k]) begin
                    acc = gf_mul(acc, base);
                end
                base = gf_mul(base, base);
            end
            tab[v] = (v == 0) ? 8'h00 : acc;
        end
        return tab;
    endfunction

    localparam t_inv_tab INV_TABLE = gf_inv_table();

endpackage

// ===== rtl/gfvo_lane.sv =====
// One byte lane: xor, multiply, or multiply-accumulate against a coefficient.
// Depends on gfvo_pkg for the operation codes and gf_mul.
`timescale 1ns / 1ps

module gfvo_lane
    import gfvo_pkg::*;
(
    input  logic [1:0] i_op,
    input  logic [7:0] i_dst,
    input  logic [7:0] i_src,
    input  logic [7:0] i_coef,
    output logic [7:0] o_res
);

    logic [7:0] w_mul_in;
    logic [7:0] w_prod;

    // Multiply-accumulate scales the source; multiply and divide scale the destination.
    assign w_mul_in = (i_op == OP_MULADD) ? i_src : i_dst;
    assign w_prod   = gf_mul(w_mul_in, i_coef);

    always_comb begin
        case (i_op)
            OP_XOR:    o_res = i_dst ^ i_src;
            OP_MUL:    o_res = w_prod;
            OP_DIV:    o_res = w_prod;
            OP_MULADD: o_res = i_dst ^ w_prod;
            default:   o_res = 8'h00;
        endcase
    end

endmodule

// ===== rtl/gfvo_merge.sv =====
// Merging stage: packs the lane results into the result word, zero-fills
// lanes not computed, and holds the output register. Depends on gfvo_pkg.
`timescale 1ns / 1ps

module gfvo_merge
    import gfvo_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [WORD_BYTES-1:0][7:0]      i_lane_res,
    input  t_ctrl                           i_ctrl,
    output logic [WORD_W-1:0]               o_result_word,
    output logic                            o_last_out,
    output logic                            o_div_zero
);

    logic [WORD_W-1:0] n_word;
    logic [WORD_W-1:0] r_word;
    logic              r_last;
    logic              r_dz;

    always_comb begin
        n_word = '0;
        for (int k = 0; k < ACT_LANES; k++) begin
            n_word[k*8 +: 8] = i_lane_res[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
            r_last <= i_ctrl.last;
            r_dz   <= i_ctrl.div_zero;
        end
    end

    assign o_result_word = r_word;
    assign o_last_out    = r_last;
    assign o_div_zero    = r_dz;

endmodule

// ===== rtl/gf256_symbol_vector_ops.sv =====
// Top level of the GF(256) symbol vector block: input stage with inverse
// lookup, parallel byte lanes, and the merging output stage.
// Depends on gfvo_pkg, gfvo_lane and gfvo_merge.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-------------------------------------------
//   input   | i_valid | o_stall | i_op i_dst_word i_src_word i_coef i_last_in
//   output  | o_valid | i_stall | o_result_word o_last_out o_div_zero
//
// One word per cycle sustained while the output is not stalled; each word reaches
// the output through the inverse table lookup stage, then lane multiply and merge.
// Reset is synchronous, active low, and empties both stages.
// The output stage holds while the output is stalled, and the first stage
// still fills behind it; the input is stalled only once both stages are full.
`timescale 1ns / 1ps

module gf256_symbol_vector_ops
    import gfvo_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_op,
    input  logic [WORD_W-1:0]   i_dst_word,
    input  logic [WORD_W-1:0]   i_src_word,
    input  logic [7:0]          i_coef,
    input  logic                i_last_in,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [WORD_W-1:0]   o_result_word,
    output logic                o_last_out,
    output logic                o_div_zero
);

    logic                       r_v1;
    logic                       r_v2;
    logic                       w_adv1;
    logic                       w_adv2;
    logic [WORD_W-1:0]          r_dst;
    logic [WORD_W-1:0]          r_src;
    logic [7:0]                 r_coef;
    t_ctrl                      r_ctrl;
    logic [7:0]                 n_coef;
    t_ctrl                      n_ctrl;
    logic [WORD_BYTES-1:0][7:0] w_lane_res;

    assign w_adv2  = !r_v2 || !i_stall;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_stall = !w_adv1;
    assign o_valid = r_v2;

    // Divide turns into multiply by the inverse; a zero inverse yields zero.
    always_comb begin
        n_coef          = (i_op == OP_DIV) ? INV_TABLE[i_coef] : i_coef;
        n_ctrl.op       = i_op;
        n_ctrl.div_zero = (i_op == OP_DIV) && (i_coef == 8'h00);
        n_ctrl.last     = i_last_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_valid) begin
            r_dst  <= i_dst_word;
            r_src  <= i_src_word;
            r_coef <= n_coef;
            r_ctrl <= n_ctrl;
        end
    end

    for (genvar g = 0; g < WORD_BYTES; g++) begin : g_lane
        if (g < ACT_LANES) begin : g_on
            gfvo_lane u_lane (
                .i_op   (r_ctrl.op),
                .i_dst  (r_dst[g*8 +: 8]),
                .i_src  (r_src[g*8 +: 8]),
                .i_coef (r_coef),
                .o_res  (w_lane_res[g])
            );
        end else begin : g_off
            assign w_lane_res[g] = 8'h00;
        end
    end

    gfvo_merge u_merge (
        .i_clk         (i_clk),
        .i_load        (w_adv2 && r_v1),
        .i_lane_res    (w_lane_res),
        .i_ctrl        (r_ctrl),
        .o_result_word (o_result_word),
        .o_last_out    (o_last_out),
        .o_div_zero    (o_div_zero)
    );

    // The input is held off only when both stages are occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2))
        else $error("input stalled with a free stage");

    // A stalled result must still be present on the next cycle.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && i_stall) |=> r_v2)
        else $error("stalled result was dropped");

    // A word waiting in the first stage is never lost while the output stalls.
    a_hold_v1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && i_stall) |=> r_v1)
        else $error("first stage lost a word");

    // Division by zero always gives a zero word.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |-> (o_result_word == '0))
        else $error("divide by zero gave a nonzero word");

    // A transfer into an empty pipeline reaches the output via the first and output stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !r_v1 && !r_v2) |=> ##1 o_valid)
        else $error("result missing after two cycles");

endmodule
